// File: design/scpu_pkg.sv
// ----------------------------------------------------------------------------
// scpu_pkg
// Shared types, codes, port decode and remap functions for the paging unit.
// ----------------------------------------------------------------------------
package scpu_pkg;

    // Access kinds
    localparam logic [1:0] MODE_MEM_READ = 2'd0;
    localparam logic [1:0] MODE_IO_READ  = 2'd1;
    localparam logic [1:0] MODE_IO_WRITE = 2'd2;
    localparam logic [1:0] MODE_NMI      = 2'd3;

    // Machine variants
    localparam logic [1:0] MT_48K     = 2'd0;
    localparam logic [1:0] MT_128K    = 2'd1;
    localparam logic [1:0] MT_1024K   = 2'd2;
    localparam logic [1:0] MT_LAYERED = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_MACHINE_TYPE    = 2'd0;
    localparam logic [1:0] CFG_DISK_ROM_ENABLE = 2'd1;
    localparam logic [1:0] CFG_LAYER_MASK      = 2'd2;
    localparam logic [1:0] CFG_RESET_ROM       = 2'd3;

    // Configuration reset values
    localparam logic [1:0] MACHINE_TYPE_RST    = MT_128K;
    localparam logic       DISK_ROM_ENABLE_RST = 1'b1;
    localparam logic [1:0] LAYER_MASK_RST      = 2'd3;
    localparam logic [1:0] RESET_ROM_RST       = 2'd0;

    // Canonical ports
    localparam logic [15:0] PORT_MAIN      = 16'h7ffd;
    localparam logic [15:0] PORT_EXT_PLUS  = 16'h1ffd;
    localparam logic [15:0] PORT_EXT_1024  = 16'heff7;
    localparam logic [15:0] PORT_SND_REG   = 16'hfffd;
    localparam logic [15:0] PORT_SND_DATA  = 16'hbffd;
    localparam logic [7:0]  PORT_ULA_LOW   = 8'hfe;

    // Fetch and layer switch addresses
    localparam logic [7:0]  DISK_TRAP_HIGH   = 8'h3d;
    localparam logic [15:0] DISK_EXIT_LIMIT  = 16'h3fff;
    localparam logic [15:0] LAYER_SW_MASK    = 16'hfff3;
    localparam logic [15:0] LAYER_SW_MATCH   = 16'h0100;
    localparam logic [1:0]  ROM_LOW_LAYER_SW = 2'd2;
    localparam logic [7:0]  ROM_IS_RAM       = 8'hff;
    localparam logic [7:0]  ROM_DISK         = 8'h03;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic        opcode_fetch;
    } item_t;

    // Packed so that rom_page lands in the lowest bits
    typedef struct packed {
        logic [15:0] decoded_port;
        logic        turbo_clock;
        logic        hicolour_video;
        logic        tape_level;
        logic        beeper_level;
        logic [2:0]  border_colour;
        logic        screen_select;
        logic        disk_rom_active;
        logic [5:0]  ram_page;
        logic [7:0]  rom_page;
    } result_t;

    typedef struct packed {
        logic [1:0] index;
        logic [1:0] data;
    } cfg_write_t;

    typedef struct packed {
        logic [7:0] rom;
        logic [5:0] ram;
    } map_t;

    // Layer step table: row from address bits 3..2, column is current layer
    function automatic logic [1:0] layer_lookup(input logic [1:0] row, input logic [1:0] col);
        logic [1:0] r;
        case ({row, col})
            4'h0: r = 2'd0;  4'h1: r = 2'd1;  4'h2: r = 2'd2;  4'h3: r = 2'd3;
            4'h4: r = 2'd3;  4'h5: r = 2'd3;  4'h6: r = 2'd3;  4'h7: r = 2'd2;
            4'h8: r = 2'd2;  4'h9: r = 2'd2;  4'ha: r = 2'd0;  4'hb: r = 2'd1;
            4'hc: r = 2'd1;  4'hd: r = 2'd0;  4'he: r = 2'd1;  4'hf: r = 2'd0;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    // Fold partially decoded port addresses onto canonical ports
    function automatic logic [15:0] decode_port(input logic [1:0] mt, input logic [15:0] a);
        logic [15:0] p;
        p = a;
        case (mt)
            MT_48K:
            begin
                if (p[0] == 1'b0) p = {p[15:8], PORT_ULA_LOW};
                if ((p & 16'h0021) == 16'h0001) p = 16'h001f;
            end
            MT_128K:
            begin
                if ((p & 16'h8002) == 16'h0000) p = PORT_MAIN;
                if ((p & 16'hc002) == 16'h8000) p = PORT_SND_DATA;
                if ((p & 16'hc002) == 16'hc000) p = PORT_SND_REG;
                if ((p & 16'h05a1) == 16'h0081) p = 16'hfadf;
                if ((p & 16'h05a1) == 16'h0181) p = 16'hfbdf;
                if ((p & 16'h05a1) == 16'h0581) p = 16'hffdf;
                if ((p & 16'h0003) == 16'h0002) p = {p[15:8], PORT_ULA_LOW};
                if (p[7:0] == 8'h1f) p = 16'h001f;
            end
            MT_1024K:
            begin
                if ((p & 16'h8002) == 16'h0000) p = PORT_MAIN;
                if ((p & 16'hc002) == 16'h8000) p = PORT_SND_DATA;
                if ((p & 16'hc002) == 16'hc000) p = PORT_SND_REG;
                if ((p & 16'hf008) == 16'he000) p = PORT_EXT_1024;
                if ((p & 16'h0003) == 16'h0002) p = {p[15:8], PORT_ULA_LOW};
            end
            default:
            begin
                if ((p & 16'h0023) == 16'h0001) p = 16'h00dd;
                if ((p & 16'h0523) == 16'h0003) p = 16'hfadf;
                if ((p & 16'h0523) == 16'h0103) p = 16'hfbdf;
                if ((p & 16'h0523) == 16'h0503) p = 16'hffdf;
                if ((p & 16'hc023) == 16'h0021) p = PORT_EXT_PLUS;
                if ((p & 16'hc023) == 16'h4021) p = PORT_MAIN;
                if ((p & 16'hc023) == 16'h8021) p = PORT_SND_DATA;
                if ((p & 16'hc023) == 16'hc021) p = PORT_SND_REG;
                if ((p & 16'h0023) == 16'h0022) p = {p[15:8], PORT_ULA_LOW};
                if (p[7:0] == 8'h1f) p = 16'h001f;
            end
        endcase
        return p;
    endfunction

    // Work out ROM and RAM pages from the paging registers
    function automatic map_t remap(input logic [1:0] mt, input logic [7:0] p0,
                                   input logic [7:0] p1, input logic [1:0] layer,
                                   input logic disk);
        map_t m;
        logic [7:0] rp;
        case (mt)
            MT_48K:
            begin
                m.rom = disk ? ROM_DISK : 8'h01;
                m.ram = 6'd0;
            end
            MT_128K:
            begin
                m.rom = disk ? ROM_DISK : {7'd0, p0[4]};
                m.ram = {1'b0, p0[7:6], p0[2:0]};
            end
            MT_1024K:
            begin
                m.rom = disk ? ROM_DISK : (p1[3] ? ROM_IS_RAM : {7'd0, p0[4]});
                m.ram = p1[2] ? {3'd0, p0[2:0]} : {p0[5], p0[7:6], p0[2:0]};
            end
            default:
            begin
                if (p1[0])     rp = ROM_IS_RAM;
                else if (p1[1]) rp = 8'h02;
                else if (disk)  rp = ROM_DISK;
                else            rp = {7'd0, p0[4]};
                m.rom = rp | {4'd0, layer, 2'd0};
                m.ram = {p1[7:6], p1[4], p0[2:0]};
            end
        endcase
        return m;
    endfunction

endpackage

// File: design/scpu_core.sv
// ----------------------------------------------------------------------------
// scpu_core
// Configuration and paging state, with the single-pass update for one access.
// ----------------------------------------------------------------------------
module scpu_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  scpu_pkg::cfg_write_t cfg,
    input  logic                 item_we,
    input  scpu_pkg::item_t      item,
    output scpu_pkg::result_t    result
);

    // Configuration
    logic [1:0] machine_type_reg;
    logic       disk_rom_enable_reg;
    logic [1:0] layer_mask_reg;

    // Paging state
    logic [7:0] main_paging_reg, main_paging_next;
    logic [7:0] ext_paging_reg,  ext_paging_next;
    logic [1:0] rom_layer_reg,   rom_layer_next;
    logic       locked_reg,      locked_next;
    logic       disk_reg,        disk_next;
    logic [7:0] mapped_rom_reg,  mapped_rom_next;
    logic [5:0] mapped_ram_reg,  mapped_ram_next;
    logic       screen_reg,      screen_next;
    logic [2:0] border_reg,      border_next;
    logic       beeper_reg,      beeper_next;
    logic       tape_reg,        tape_next;
    logic       video_reg,       video_next;
    logic       turbo_reg,       turbo_next;

    logic [15:0]      port;
    logic             remap_req;
    logic             main_lock_ext;
    logic             main_wr;
    scpu_pkg::map_t   new_map;

    // Configuration writes; the reset ROM select is not held in a register, so the
    // reset state always starts from its fixed reset value and a write to it
    // has nothing to act on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            machine_type_reg    <= scpu_pkg::MACHINE_TYPE_RST;
            disk_rom_enable_reg <= scpu_pkg::DISK_ROM_ENABLE_RST;
            layer_mask_reg      <= scpu_pkg::LAYER_MASK_RST;
        end
        else if (cfg_we)
        begin
            case (cfg.index)
                scpu_pkg::CFG_MACHINE_TYPE:    machine_type_reg    <= cfg.data;
                scpu_pkg::CFG_DISK_ROM_ENABLE: disk_rom_enable_reg <= cfg.data[0];
                scpu_pkg::CFG_LAYER_MASK:      layer_mask_reg      <= cfg.data;
                default: ;
            endcase
        end
    end

    // Work out the state after this access
    always_comb
    begin
        main_paging_next = main_paging_reg;
        ext_paging_next  = ext_paging_reg;
        rom_layer_next   = rom_layer_reg;
        locked_next      = locked_reg;
        disk_next        = disk_reg;
        screen_next      = screen_reg;
        border_next      = border_reg;
        beeper_next      = beeper_reg;
        tape_next        = tape_reg;
        video_next       = video_reg;
        turbo_next       = turbo_reg;
        port             = item.address;
        remap_req        = 1'b0;
        main_wr          = 1'b0;
        main_lock_ext    = 1'b0;

        case (item.mode)
            scpu_pkg::MODE_MEM_READ:
            begin
                // Step the ROM layer on a switch address
                if (machine_type_reg == scpu_pkg::MT_LAYERED &&
                    mapped_rom_reg[1:0] == scpu_pkg::ROM_LOW_LAYER_SW &&
                    (item.address & scpu_pkg::LAYER_SW_MASK) == scpu_pkg::LAYER_SW_MATCH)
                begin
                    rom_layer_next = scpu_pkg::layer_lookup(item.address[3:2], rom_layer_reg)
                                     & layer_mask_reg;
                    remap_req      = 1'b1;
                end
                // Disk ROM trap on fetches, then release above the ROM area
                if (item.opcode_fetch && disk_rom_enable_reg)
                begin
                    if (!disk_reg && item.address[15:8] == scpu_pkg::DISK_TRAP_HIGH &&
                        main_paging_reg[4])
                    begin
                        disk_next = 1'b1;
                        remap_req = 1'b1;
                    end
                    if (disk_next && item.address > scpu_pkg::DISK_EXIT_LIMIT)
                    begin
                        disk_next = 1'b0;
                        remap_req = 1'b1;
                    end
                end
            end
            scpu_pkg::MODE_IO_READ:
            begin
                port = scpu_pkg::decode_port(machine_type_reg, item.address);
                if (machine_type_reg == scpu_pkg::MT_LAYERED)
                begin
                    if (port == scpu_pkg::PORT_MAIN)          turbo_next = 1'b1;
                    else if (port == scpu_pkg::PORT_EXT_PLUS) turbo_next = 1'b0;
                end
            end
            scpu_pkg::MODE_IO_WRITE:
            begin
                port = scpu_pkg::decode_port(machine_type_reg, item.address);
                if (port == scpu_pkg::PORT_SND_REG || port == scpu_pkg::PORT_SND_DATA)
                begin
                    // sound chip: nothing to hold
                end
                else if (port[7:0] == scpu_pkg::PORT_ULA_LOW)
                begin
                    border_next = item.write_data[2:0];
                    beeper_next = item.write_data[4];
                    tape_next   = item.write_data[3];
                end
                else if (machine_type_reg == scpu_pkg::MT_128K)
                begin
                    main_wr = (port == scpu_pkg::PORT_MAIN);
                end
                else if (machine_type_reg == scpu_pkg::MT_1024K)
                begin
                    if (port == scpu_pkg::PORT_MAIN)
                    begin
                        main_wr       = 1'b1;
                        main_lock_ext = 1'b1;
                    end
                    else if (port == scpu_pkg::PORT_EXT_1024)
                    begin
                        ext_paging_next = item.write_data;
                        video_next      = item.write_data[0];
                        turbo_next      = item.write_data[4];
                        remap_req       = 1'b1;
                    end
                end
                else if (machine_type_reg == scpu_pkg::MT_LAYERED)
                begin
                    if (port == scpu_pkg::PORT_MAIN)
                    begin
                        main_wr = 1'b1;
                    end
                    else if (port == scpu_pkg::PORT_EXT_PLUS)
                    begin
                        ext_paging_next = item.write_data;
                        remap_req       = 1'b1;
                    end
                end

                // Main paging port, dropped while locked
                if (main_wr && !locked_reg)
                begin
                    main_paging_next = item.write_data;
                    screen_next      = item.write_data[3];
                    locked_next      = main_lock_ext ? (ext_paging_reg[2] & item.write_data[5])
                                                     : item.write_data[5];
                    remap_req        = 1'b1;
                end
            end
            default:
            begin
                // NMI pages the disk ROM in unconditionally
                disk_next = 1'b1;
                remap_req = 1'b1;
            end
        endcase

        new_map = scpu_pkg::remap(machine_type_reg, main_paging_next, ext_paging_next,
                                  rom_layer_next, disk_next);
        mapped_rom_next = remap_req ? new_map.rom : mapped_rom_reg;
        mapped_ram_next = remap_req ? new_map.ram : mapped_ram_reg;
    end

    // Hold the paging state, advance on each accepted access
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_paging_reg <= {3'd0, scpu_pkg::RESET_ROM_RST[0], 4'd0};
            ext_paging_reg  <= 8'd0;
            rom_layer_reg   <= 2'd0;
            locked_reg      <= 1'b0;
            disk_reg        <= (scpu_pkg::RESET_ROM_RST == 2'd3);
            mapped_rom_reg  <= {6'd0, scpu_pkg::RESET_ROM_RST};
            mapped_ram_reg  <= 6'd0;
            screen_reg      <= 1'b0;
            border_reg      <= 3'd0;
            beeper_reg      <= 1'b0;
            tape_reg        <= 1'b0;
            video_reg       <= 1'b0;
            turbo_reg       <= 1'b0;
        end
        else if (item_we)
        begin
            main_paging_reg <= main_paging_next;
            ext_paging_reg  <= ext_paging_next;
            rom_layer_reg   <= rom_layer_next;
            locked_reg      <= locked_next;
            disk_reg        <= disk_next;
            mapped_rom_reg  <= mapped_rom_next;
            mapped_ram_reg  <= mapped_ram_next;
            screen_reg      <= screen_next;
            border_reg      <= border_next;
            beeper_reg      <= beeper_next;
            tape_reg        <= tape_next;
            video_reg       <= video_next;
            turbo_reg       <= turbo_next;
        end
    end

    // Result reflects the state after the access
    always_comb
    begin
        result.rom_page        = mapped_rom_next;
        result.ram_page        = mapped_ram_next;
        result.disk_rom_active = disk_next;
        result.screen_select   = screen_next;
        result.border_colour   = border_next;
        result.beeper_level    = beeper_next;
        result.tape_level      = tape_next;
        result.hicolour_video  = video_next;
        result.turbo_clock     = turbo_next;
        result.decoded_port    = port;
    end

`ifndef SYNTHESIS
    // The paging lock is released by reset only
    a_lock_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(locked_reg))
        else $error("paging lock released without reset");

    // The ROM layer moves only on a memory read on the layered variant
    a_layer_source: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(rom_layer_reg) |-> $past(item_we && item.mode == scpu_pkg::MODE_MEM_READ &&
                                          machine_type_reg == scpu_pkg::MT_LAYERED))
        else $error("ROM layer changed outside a layer switch");
`endif

endmodule

// File: design/spectrum_clone_paging_unit.sv
// ----------------------------------------------------------------------------
// spectrum_clone_paging_unit
// Paging and port decode unit: one bus access in, one paging snapshot out.
// ----------------------------------------------------------------------------
// Throughput: one access per cycle while no skid entry is held; the paging
// update is a single combinational pass into the state and result registers.
// A two-entry output stage keeps input transfers going while a result waits.
// Reset (rst_n, asynchronous, active low) clears the handshake state and puts
// configuration and paging registers at their reset values at once.
module spectrum_clone_paging_unit (
    input  logic        clk,
    input  logic        rst_n,
    // Access stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] address, [23:16] write_data
    input  logic [2:0]  s_tuser,   // [1:0] mode, [2] opcode_fetch
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] rom_page, [13:8] ram_page,
                                   // [14] disk_rom_active, [15] screen_select,
                                   // [18:16] border_colour, [19] beeper_level,
                                   // [20] tape_level, [21] hicolour_video,
                                   // [22] turbo_clock, [38:23] decoded_port
    // Configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [1:0]  cfg_data
);

    scpu_pkg::item_t      item;
    scpu_pkg::cfg_write_t cfg;
    scpu_pkg::result_t    result;
    scpu_pkg::result_t    out_reg;
    scpu_pkg::result_t    skid_reg;
    logic                 out_valid_reg;
    logic                 skid_valid_reg;
    logic                 in_xfer;
    logic                 cfg_xfer;

    // Unpack the access
    assign item.mode         = s_tuser[1:0];
    assign item.opcode_fetch = s_tuser[2];
    assign item.address      = s_tdata[15:0];
    assign item.write_data   = s_tdata[23:16];

    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid & cfg_ready;
    assign s_tready  = !skid_valid_reg;
    assign in_xfer   = s_tvalid & s_tready;

    scpu_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_we  (cfg_xfer),
        .cfg     (cfg),
        .item_we (in_xfer),
        .item    (item),
        .result  (result)
    );

    // Output register and skid entry: control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= in_xfer;
            end
            else
            begin
                out_valid_reg <= in_xfer;
            end
        end
        else if (in_xfer)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Output register and skid entry: payload
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
                if (in_xfer)
                begin
                    skid_reg <= result;
                end
            end
            else if (in_xfer)
            begin
                out_reg <= result;
            end
        end
        else if (in_xfer)
        begin
            skid_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg};

`ifndef SYNTHESIS
    // A waiting skid entry always sits behind a valid output
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with no output result");

    // Every transfer in is followed by a valid output on the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> m_tvalid)
        else $error("accepted access produced no result");

    // A drained output is refilled from the skid entry
    a_skid_refill: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && m_tready) |=> m_tvalid)
        else $error("skid entry lost after output transfer");
`endif

endmodule
